FILE: hdl/gnc_pkg.sv
// Package for the group normalization block: widths, op codes, sequencer
// states and the divider request/response types. No dependencies.
package gnc_pkg;

    localparam int unsigned MAX_GROUP_ELEMENTS_DEF = 1048576;

    localparam int DATA_W  = 16;
    localparam int OP_W    = 2;
    localparam int INV_W   = 24;
    localparam int DIV_W   = 64;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 27;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MSQ_W   = 31;
    localparam int V_W     = 32;
    localparam int Q48_W   = 49;
    localparam int Q50_W   = 51;
    localparam int ROOT_W  = 25;
    localparam int BIT_W   = 5;
    localparam int CMP_W   = 52;
    localparam int T_W     = 60;

    localparam logic [OP_W-1:0] OP_ACC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_NORM = 2'd2;

    localparam logic [INV_W-1:0] INV_MAX = {INV_W{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_FIN_MEAN,
        ST_FIN_MEAN_W,
        ST_FIN_MSQ,
        ST_FIN_MSQ_W,
        ST_FIN_M2,
        ST_FIN_VAR,
        ST_FIN_Q48,
        ST_FIN_Q48_W,
        ST_FIN_Q50,
        ST_FIN_Q50_W,
        ST_SQRT_MUL,
        ST_SQRT_CMP,
        ST_RND_MUL,
        ST_RND_CMP,
        ST_FIN_OUT,
        ST_NRM_MUL1,
        ST_NRM_MUL2,
        ST_NRM_ADD,
        ST_NRM_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hdl/gnc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on gnc_pkg (div_req_t, div_rsp_t, DIV_W).
module gnc_div import gnc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvs_reg;

    logic [DIV_W:0] rem_sh;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        ge     = !diff[DIV_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            cnt_reg <= '0;
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hdl/group_norm_channel_major.sv
// Group normalization: accumulate, finish (mean, inverse deviation) and normalize beats
// through one shared multiplier and one iterative divider. Depends on gnc_pkg, gnc_div.
//
// One beat is taken at a time; s_ready is high only while the sequencer is idle, and a
// result waiting in the output register does not block the next beat until that beat's own
// result is due. Finish runs up to four divisions (mean, mean square, 2^48/v, 2^50/v) and
// 25 square root steps on the shared multiplier. epsilon is written through cfg_* while no
// beat is pending: a rule for the user that the block itself does not enforce.
module group_norm_channel_major import gnc_pkg::*; #(
    parameter int unsigned MAX_GROUP_ELEMENTS = MAX_GROUP_ELEMENTS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic signed [DATA_W-1:0] s_sample,
    input  logic signed [DATA_W-1:0] s_gain,
    input  logic signed [DATA_W-1:0] s_bias,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_value,
    output logic [INV_W-1:0]         m_inverse_deviation,
    output logic                     m_empty_group,
    output logic                     m_saturated
);

    localparam int CNT_W = $clog2(MAX_GROUP_ELEMENTS + 1);
    localparam int SUM_W = DATA_W + CNT_W;
    localparam int SQ_W  = 30 + CNT_W;

    state_t state_reg, state_next;

    logic                     m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]        eps_reg, eps_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] gmean_reg, gmean_next;
    logic [INV_W-1:0]         ginv_reg, ginv_next;

    logic signed [DATA_W-1:0] sample_reg, sample_next;
    logic signed [DATA_W-1:0] gain_reg, gain_next;
    logic signed [DATA_W-1:0] bias_reg, bias_next;
    logic                     empty_reg, empty_next;
    logic signed [DATA_W-1:0] mean_reg, mean_next;
    logic [MSQ_W-1:0]         msq_reg, msq_next;
    logic [V_W-1:0]           v_reg, v_next;
    logic [Q48_W-1:0]         q48_reg, q48_next;
    logic [Q50_W-1:0]         q50_reg, q50_next;
    logic [ROOT_W-1:0]        y_reg, y_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [INV_W-1:0]         inv_reg, inv_next;
    logic                     sat_reg, sat_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic signed [DATA_W-1:0] m_value_reg, m_value_next;
    logic [INV_W-1:0]         m_inv_reg, m_inv_next;
    logic                     m_empty_reg, m_empty_next;
    logic                     m_sat_reg, m_sat_next;
    logic signed [MUL_P_W-1:0] mul_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [SUM_W-1:0]         mag;
    logic signed [DATA_W:0]   qm;
    logic signed [DATA_W:0]   mean_w;
    logic [MSQ_W-1:0]         m2;
    logic [MSQ_W-1:0]         var_w;
    logic [ROOT_W-1:0]        cand;
    logic [ROOT_W:0]          odd;
    logic [ROOT_W:0]          yr;
    logic signed [DATA_W:0]   diff;
    logic signed [T_W-1:0]    t;
    logic [T_W-1:0]           tmag;
    logic [T_W-25:0]          r;
    logic                     out_free;
    logic                     s_fire;

    gnc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        mag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        qm       = $signed({1'b0, div_rsp.quotient[DATA_W-1:0]});
        mean_w   = sum_reg[SUM_W-1] ? -qm : qm;
        m2       = mul_reg[MSQ_W-1:0];
        var_w    = (msq_reg > m2) ? msq_reg - m2 : '0;
        cand     = y_reg | (ROOT_W'(1) << bit_reg);
        odd      = {y_reg, 1'b1};
        yr       = {1'b0, y_reg} + ROOT_W'(mul_reg[CMP_W-1:0] <= CMP_W'(q50_reg));
        diff     = (DATA_W+1)'(sample_reg) - (DATA_W+1)'(gmean_reg);
        t        = T_W'(mul_reg) + (T_W'(bias_reg) <<< 24);
        tmag     = t[T_W-1] ? T_W'(-t) : T_W'(t);
        r        = (T_W-24)'((tmag + (T_W'(1) << 23)) >> 24);
        out_free = !m_valid_reg || m_ready;
        s_fire   = s_valid && (state_reg == ST_IDLE);
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        eps_next     = (cfg_valid && cfg_ready) ? cfg_data : eps_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        count_next   = count_reg;
        gmean_next   = gmean_reg;
        ginv_next    = ginv_reg;
        sample_next  = sample_reg;
        gain_next    = gain_reg;
        bias_next    = bias_reg;
        empty_next   = empty_reg;
        mean_next    = mean_reg;
        msq_next     = msq_reg;
        v_next       = v_reg;
        q48_next     = q48_reg;
        q50_next     = q50_reg;
        y_next       = y_reg;
        bit_next     = bit_reg;
        inv_next     = inv_reg;
        sat_next     = sat_reg;
        res_next     = res_reg;
        m_value_next = m_value_reg;
        m_inv_next   = m_inv_reg;
        m_empty_next = m_empty_reg;
        m_sat_next   = m_sat_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_req      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    sample_next = s_sample;
                    gain_next   = s_gain;
                    bias_next   = s_bias;
                    empty_next  = (count_reg == '0);
                    priority if (s_op == OP_ACC) begin
                        if (count_reg < CNT_W'(MAX_GROUP_ELEMENTS)) begin
                            state_next = ST_ACC_MUL;
                        end
                    end else if (s_op == OP_FIN) begin
                        if (count_reg == '0) begin
                            mean_next  = '0;
                            msq_next   = '0;
                            state_next = ST_FIN_M2;
                        end else begin
                            state_next = ST_FIN_MEAN;
                        end
                    end else if (s_op == OP_NORM) begin
                        state_next = ST_NRM_MUL1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ACC_MUL: begin
                mul_a      = MUL_A_W'(sample_reg);
                mul_b      = MUL_B_W'(sample_reg);
                state_next = ST_ACC_ADD;
            end
            ST_ACC_ADD: begin
                sum_next   = sum_reg + SUM_W'(sample_reg);
                sq_next    = sq_reg + SQ_W'(mul_reg[30:0]);
                count_next = count_reg + 1'b1;
                state_next = ST_IDLE;
            end
            ST_FIN_MEAN: begin
                div_req.start    = 1'b1;
                div_req.dividend = (DIV_W'(mag) << 1) + DIV_W'(count_reg);
                div_req.divisor  = DIV_W'(count_reg) << 1;
                state_next       = ST_FIN_MEAN_W;
            end
            ST_FIN_MEAN_W: begin
                if (div_rsp.done) begin
                    mean_next  = mean_w[DATA_W-1:0];
                    state_next = ST_FIN_MSQ;
                end
            end
            ST_FIN_MSQ: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(sq_reg);
                div_req.divisor  = DIV_W'(count_reg);
                state_next       = ST_FIN_MSQ_W;
            end
            ST_FIN_MSQ_W: begin
                if (div_rsp.done) begin
                    msq_next   = div_rsp.quotient[MSQ_W-1:0];
                    state_next = ST_FIN_M2;
                end
            end
            ST_FIN_M2: begin
                mul_a      = MUL_A_W'(mean_reg);
                mul_b      = MUL_B_W'(mean_reg);
                state_next = ST_FIN_VAR;
            end
            ST_FIN_VAR: begin
                v_next     = V_W'(var_w) + V_W'(eps_reg);
                sum_next   = '0;
                sq_next    = '0;
                count_next = '0;
                if ((V_W'(var_w) + V_W'(eps_reg)) == '0) begin
                    inv_next   = INV_MAX;
                    sat_next   = 1'b1;
                    state_next = ST_FIN_OUT;
                end else begin
                    state_next = ST_FIN_Q48;
                end
            end
            ST_FIN_Q48: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(1) << 48;
                div_req.divisor  = DIV_W'(v_reg);
                state_next       = ST_FIN_Q48_W;
            end
            ST_FIN_Q48_W: begin
                if (div_rsp.done) begin
                    q48_next   = div_rsp.quotient[Q48_W-1:0];
                    state_next = ST_FIN_Q50;
                end
            end
            ST_FIN_Q50: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(1) << 50;
                div_req.divisor  = DIV_W'(v_reg);
                state_next       = ST_FIN_Q50_W;
            end
            ST_FIN_Q50_W: begin
                if (div_rsp.done) begin
                    q50_next   = div_rsp.quotient[Q50_W-1:0];
                    y_next     = '0;
                    bit_next   = BIT_W'(ROOT_W - 1);
                    state_next = ST_SQRT_MUL;
                end
            end
            ST_SQRT_MUL: begin
                mul_a      = MUL_A_W'(cand);
                mul_b      = MUL_B_W'(cand);
                state_next = ST_SQRT_CMP;
            end
            ST_SQRT_CMP: begin
                if (mul_reg[CMP_W-1:0] <= CMP_W'(q48_reg)) begin
                    y_next = cand;
                end
                if (bit_reg == '0) begin
                    state_next = ST_RND_MUL;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_SQRT_MUL;
                end
            end
            ST_RND_MUL: begin
                mul_a      = MUL_A_W'(odd);
                mul_b      = MUL_B_W'(odd);
                state_next = ST_RND_CMP;
            end
            ST_RND_CMP: begin
                if (yr > (ROOT_W+1)'(INV_MAX)) begin
                    inv_next = INV_MAX;
                    sat_next = 1'b1;
                end else begin
                    inv_next = yr[INV_W-1:0];
                    sat_next = 1'b0;
                end
                state_next = ST_FIN_OUT;
            end
            ST_FIN_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = mean_reg;
                    m_inv_next   = inv_reg;
                    m_empty_next = empty_reg;
                    m_sat_next   = sat_reg;
                    gmean_next   = mean_reg;
                    ginv_next    = inv_reg;
                    sat_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            ST_NRM_MUL1: begin
                mul_a      = MUL_A_W'(diff);
                mul_b      = MUL_B_W'(gain_reg);
                state_next = ST_NRM_MUL2;
            end
            ST_NRM_MUL2: begin
                mul_a      = MUL_A_W'(mul_reg);
                mul_b      = MUL_B_W'({1'b0, ginv_reg});
                state_next = ST_NRM_ADD;
            end
            ST_NRM_ADD: begin
                if (t[T_W-1]) begin
                    if (r > (T_W-24)'(32768)) begin
                        res_next = DATA_W'(-32768);
                        sat_next = 1'b1;
                    end else begin
                        res_next = DATA_W'(-$signed(r));
                        sat_next = 1'b0;
                    end
                end else begin
                    if (r > (T_W-24)'(32767)) begin
                        res_next = DATA_W'(32767);
                        sat_next = 1'b1;
                    end else begin
                        res_next = r[DATA_W-1:0];
                        sat_next = 1'b0;
                    end
                end
                state_next = ST_NRM_OUT;
            end
            ST_NRM_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_reg;
                    m_inv_next   = ginv_reg;
                    m_empty_next = 1'b0;
                    m_sat_next   = sat_reg;
                    sat_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            eps_reg     <= DATA_W'(1);
            sum_reg     <= '0;
            sq_reg      <= '0;
            count_reg   <= '0;
            gmean_reg   <= '0;
            ginv_reg    <= '0;
            sat_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            eps_reg     <= eps_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            count_reg   <= count_next;
            gmean_reg   <= gmean_next;
            ginv_reg    <= ginv_next;
            sat_reg     <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        gain_reg    <= gain_next;
        bias_reg    <= bias_next;
        empty_reg   <= empty_next;
        mean_reg    <= mean_next;
        msq_reg     <= msq_next;
        v_reg       <= v_next;
        q48_reg     <= q48_next;
        q50_reg     <= q50_next;
        y_reg       <= y_next;
        bit_reg     <= bit_next;
        inv_reg     <= inv_next;
        res_reg     <= res_next;
        m_value_reg <= m_value_next;
        m_inv_reg   <= m_inv_next;
        m_empty_reg <= m_empty_next;
        m_sat_reg   <= m_sat_next;
        mul_reg     <= mul_a * mul_b;
    end

    assign cfg_ready           = 1'b1;
    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_value             = m_value_reg;
    assign m_inverse_deviation = m_inv_reg;
    assign m_empty_group       = m_empty_reg;
    assign m_saturated         = m_sat_reg;

endmodule

FILE: tb/group_norm_channel_major_test.sv
// Testbench for group_norm_channel_major: streams accumulate, finish and normalize beats,
// predicts mean, inverse deviation and normalized values. Depends on gnc_pkg and the RTL.
module group_norm_channel_major_test;
    import gnc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] gain;
        logic signed [DATA_W-1:0] bias;
    } beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [INV_W-1:0]         inv;
        logic                     empty;
        logic                     sat;
    } norm_out_t;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_op = '0;
    logic signed [DATA_W-1:0] s_sample = '0, s_gain = '0, s_bias = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_value;
    logic [INV_W-1:0] m_inverse_deviation;
    logic m_empty_group, m_saturated;

    group_norm_channel_major uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_sample(s_sample),
        .s_gain(s_gain), .s_bias(s_bias),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value),
        .m_inverse_deviation(m_inverse_deviation), .m_empty_group(m_empty_group),
        .m_saturated(m_saturated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [15:0]        eps_reg = 16'd1;
    longint             acc_sum = 0;
    longint unsigned    acc_sq = 0;
    int unsigned        acc_cnt = 0;
    int                 held_mean = 0;
    int unsigned        held_inv = 0;

    beat_t     pending_beats[$];
    norm_out_t expected_outs[$];
    int        errors = 0;

    function automatic int unsigned inverse_sqrt(longint unsigned v);
        longint unsigned q48, q50, y, c, b;
        q48 = (64'd1 << 48) / v;
        q50 = (64'd1 << 50) / v;
        y = 0;
        b = 64'd1 << 24;
        while (b != 0) begin
            c = y | b;
            if (c * c <= q48) y = c;
            b = b >> 1;
        end
        if ((2 * y + 1) * (2 * y + 1) <= q50) y = y + 1;
        return int'(y);
    endfunction

    task automatic predict_beat(beat_t b);
        norm_out_t r;
        longint unsigned n, mag, qm, msq, m2, vr, v;
        longint d, t;
        int mean;
        int unsigned inv;
        r = '0;
        case (b.op)
            OP_ACC: begin
                if (acc_cnt < MAX_GROUP_ELEMENTS_DEF) begin
                    acc_sum += longint'(b.sample);
                    acc_sq += longint'(b.sample) * longint'(b.sample);
                    acc_cnt++;
                end
            end
            OP_FIN: begin
                mean = 0;
                vr = 0;
                if (acc_cnt != 0) begin
                    n = acc_cnt;
                    mag = acc_sum < 0 ? -acc_sum : acc_sum;
                    qm = (2 * mag + n) / (2 * n);
                    msq = acc_sq / n;
                    mean = acc_sum < 0 ? -int'(qm) : int'(qm);
                    m2 = longint'(mean) * longint'(mean);
                    vr = msq > m2 ? msq - m2 : 0;
                end
                v = vr + eps_reg;
                if (v == 0) begin
                    inv = 32'hFFFFFF;
                    r.sat = 1'b1;
                end else begin
                    inv = inverse_sqrt(v);
                    if (inv > 32'hFFFFFF) begin
                        inv = 32'hFFFFFF;
                        r.sat = 1'b1;
                    end
                end
                r.empty = (acc_cnt == 0);
                r.value = mean[15:0];
                r.inv = inv[23:0];
                held_mean = mean;
                held_inv = inv;
                acc_sum = 0;
                acc_sq = 0;
                acc_cnt = 0;
                expected_outs.push_back(r);
            end
            OP_NORM: begin
                d = longint'(b.sample) - held_mean;
                t = d * longint'(held_inv) * longint'(b.gain) + (longint'(b.bias) <<< 24);
                mag = t < 0 ? -t : t;
                mag = (mag + (64'd1 << 23)) >> 24;
                if (t < 0) begin
                    if (mag > 32768) begin mag = 32768; r.sat = 1'b1; end
                    d = -longint'(mag);
                end else begin
                    if (mag > 32767) begin mag = 32767; r.sat = 1'b1; end
                    d = longint'(mag);
                end
                r.value = d[15:0];
                r.inv = held_inv[23:0];
                expected_outs.push_back(r);
            end
            default: ;
        endcase
    endtask

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (s_valid && s_ready) predict_beat({s_op, s_sample, s_gain, s_bias});
        if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (aresetn && pending_beats.size() > 0) begin
                {s_op, s_sample, s_gain, s_bias} <= pending_beats.pop_front();
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase = 0;
    always @(posedge aclk) begin
        norm_out_t e;
        if (m_valid && m_ready) begin
            if (expected_outs.size() == 0) begin
                $error("unexpected beat value=%0d", m_value);
                errors++;
            end else begin
                e = expected_outs.pop_front();
                if (m_value !== e.value) begin
                    $error("value exp %0d got %0d", e.value, m_value); errors++;
                end
                if (m_inverse_deviation !== e.inv) begin
                    $error("inverse_deviation exp %0d got %0d", e.inv, m_inverse_deviation);
                    errors++;
                end
                if (m_empty_group !== e.empty) begin
                    $error("empty_group exp %0d got %0d", e.empty, m_empty_group); errors++;
                end
                if (m_saturated !== e.sat) begin
                    $error("saturated exp %0d got %0d", e.sat, m_saturated); errors++;
                end
            end
        end
        stall_phase <= (stall_phase + 1) % 64;
        m_ready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    function automatic beat_t mk(logic [OP_W-1:0] op, int s, int g, int b);
        beat_t x;
        x.op = op; x.sample = s[15:0]; x.gain = g[15:0]; x.bias = b[15:0];
        return x;
    endfunction

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_valid || expected_outs.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_epsilon(logic [15:0] val);
        @(posedge aclk);
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        eps_reg = val;
        cfg_valid <= 1'b0;
    endtask

    function automatic int rnd_sample(int mode);
        case (mode)
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 1024)) - 512;
            default: return int'($urandom_range(0, 64)) + 200;
        endcase
    endfunction

    task automatic random_groups(int items);
        int k, n, m, mode;
        k = 0;
        while (k < items) begin
            mode = $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) begin
                pending_beats.push_back(mk(OP_W'($urandom_range(0, 3)), rnd_sample(0),
                    rnd_sample(0), rnd_sample(0)));
                k++;
            end
            n = $urandom_range(0, 12);
            repeat (n) pending_beats.push_back(mk(OP_ACC, rnd_sample(mode), 0, 0));
            pending_beats.push_back(mk(OP_FIN, 0, 0, 0));
            m = $urandom_range(1, 14);
            repeat (m)
                pending_beats.push_back(mk(OP_NORM, rnd_sample(mode),
                    ($urandom_range(0, 3) == 0) ? 256 : rnd_sample(0),
                    ($urandom_range(0, 3) == 0) ? 0 : rnd_sample(0)));
            k += n + 1 + m;
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // directed
        pending_beats.push_back(mk(OP_NORM, 100, 256, -32768));
        pending_beats.push_back(mk(OP_NONE, -1, -1, -1));
        pending_beats.push_back(mk(OP_FIN, 0, 0, 0));
        pending_beats.push_back(mk(OP_NORM, 32767, 32767, 32767));
        pending_beats.push_back(mk(OP_NORM, -32768, -32768, 0));
        pending_beats.push_back(mk(OP_ACC, 32767, 0, 0));
        pending_beats.push_back(mk(OP_ACC, -32768, 0, 0));
        pending_beats.push_back(mk(OP_ACC, 32767, 0, 0));
        pending_beats.push_back(mk(OP_FIN, 0, 0, 0));
        pending_beats.push_back(mk(OP_NORM, 32767, 32767, 32767));
        pending_beats.push_back(mk(OP_NORM, -32768, 32767, -32768));
        pending_beats.push_back(mk(OP_NORM, 0, 256, 0));
        pending_beats.push_back(mk(OP_ACC, 5, 0, 0));
        pending_beats.push_back(mk(OP_ACC, 5, 0, 0));
        pending_beats.push_back(mk(OP_FIN, 0, 0, 0));
        pending_beats.push_back(mk(OP_NORM, 6, -32768, 100));
        wait_drained();
        write_epsilon(16'd0);
        pending_beats.push_back(mk(OP_FIN, 0, 0, 0));
        pending_beats.push_back(mk(OP_ACC, 7, 0, 0));
        pending_beats.push_back(mk(OP_FIN, 0, 0, 0));
        pending_beats.push_back(mk(OP_NORM, 8, 256, 0));
        random_groups(200);
        wait_drained();
        write_epsilon(16'hFFFF);
        pending_beats.push_back(mk(OP_FIN, 0, 0, 0));
        random_groups(250);
        wait_drained();
        write_epsilon(16'($urandom_range(1, 65534)));
        random_groups(250);
        wait_drained();
        write_epsilon(16'd1);
        random_groups(200);
        wait_drained();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
